@@ src/stw_pkg.sv @@
// ----------------------------------------------------------------------------
// stw_pkg
// shared types and constants of the sequential transducer walk
// ----------------------------------------------------------------------------
package stw_pkg;

  // default table geometry
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned LabelBits  = 12;

  // fixed beat field widths
  localparam int unsigned FieldBits = 12;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned CountBits = 11;

  typedef enum logic [0:0] {
    OpLoad  = 1'b0,
    OpApply = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StCompare,
    StDone
  } state_e;

  typedef struct packed {
    logic [0:0]           operation;
    logic [IndexBits-1:0] arc_index;
    logic [FieldBits-1:0] arc_source;
    logic [FieldBits-1:0] arc_input_label;
    logic [FieldBits-1:0] arc_output_label;
    logic [FieldBits-1:0] arc_target;
    logic [FieldBits-1:0] symbol;
    logic                 first_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [FieldBits-1:0] out_symbol;
    logic                 found;
    logic [FieldBits-1:0] next_state;
  } out_beat_t;

endpackage

@@ src/stw_arc_ram.sv @@
// ----------------------------------------------------------------------------
// stw_arc_ram
// arc table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module stw_arc_ram #(
  parameter int unsigned Depth = stw_pkg::TableDepth,
  parameter int unsigned Width = 4 * stw_pkg::LabelBits,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [Width-1:0]    wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [Width-1:0]    rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/stw_search.sv @@
// ----------------------------------------------------------------------------
// stw_search
// binary search sequencer with one shared key compare, holds the current state
// ----------------------------------------------------------------------------
module stw_search #(
  parameter int unsigned TableDepth = stw_pkg::TableDepth,
  parameter int unsigned LabelBits  = stw_pkg::LabelBits,
  localparam int unsigned AddrBits  = $clog2(TableDepth),
  localparam int unsigned CntBits   = $clog2(TableDepth + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              first_i,
  input  logic [stw_pkg::FieldBits-1:0]     symbol_i,
  input  logic [CntBits-1:0]                hi_init_i,
  output logic                              busy_o,
  output logic                              rd_en_o,
  output logic [AddrBits-1:0]               rd_addr_o,
  input  logic [4*LabelBits-1:0]            rd_data_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output stw_pkg::out_beat_t                res_o
);

  stw_pkg::state_e state_q, state_d;

  logic [CntBits-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [LabelBits-1:0] cur_q, cur_d, sym_q, sym_d, rsym_q, rsym_d;
  logic                 rfound_q, rfound_d;

  logic [LabelBits-1:0]   ent_src, ent_in, ent_out, ent_dst;
  logic [2*LabelBits-1:0] ent_key, probe_key;
  logic                   key_eq, key_lt;

  function automatic logic [CntBits-1:0] mid_of(input logic [CntBits-1:0] a,
                                                input logic [CntBits-1:0] b);
    logic [CntBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntBits:1];
  endfunction

  // entry fields: source, input label, output label, target
  assign ent_src = rd_data_i[4*LabelBits-1:3*LabelBits];
  assign ent_in  = rd_data_i[3*LabelBits-1:2*LabelBits];
  assign ent_out = rd_data_i[2*LabelBits-1:LabelBits];
  assign ent_dst = rd_data_i[LabelBits-1:0];

  // shared compare: (source, label) against (state, symbol)
  assign ent_key   = {ent_src, ent_in};
  assign probe_key = {cur_q, sym_q};
  assign key_eq    = (ent_key == probe_key);
  assign key_lt    = (ent_key < probe_key);

  // datapath
  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    cur_d    = cur_q;
    sym_d    = sym_q;
    rsym_d   = rsym_q;
    rfound_d = rfound_q;
    rd_en_o  = 1'b0;
    unique case (state_q)
      stw_pkg::StIdle: begin
        if (start_i) begin
          sym_d    = LabelBits'(symbol_i);
          lo_d     = '0;
          hi_d     = hi_init_i;
          rsym_d   = '0;
          rfound_d = 1'b0;
          if (first_i) begin
            cur_d = '0;
          end
        end
      end
      stw_pkg::StIssue: begin
        mid_d   = mid_of(lo_q, hi_q);
        rd_en_o = (lo_q < hi_q);
      end
      stw_pkg::StCompare: begin
        if (key_eq) begin
          rfound_d = 1'b1;
          rsym_d   = ent_out;
          cur_d    = ent_dst;
        end else begin
          if (key_lt) begin
            lo_d = mid_q + CntBits'(1);
          end else begin
            hi_d = mid_q;
          end
          mid_d   = mid_of(lo_d, hi_d);
          rd_en_o = (lo_d < hi_d);
        end
      end
      stw_pkg::StDone: begin
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_o = mid_d[AddrBits-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stw_pkg::StIdle:    if (start_i) state_d = stw_pkg::StIssue;
      stw_pkg::StIssue:   state_d = rd_en_o ? stw_pkg::StCompare : stw_pkg::StDone;
      stw_pkg::StCompare: state_d = rd_en_o ? stw_pkg::StCompare : stw_pkg::StDone;
      stw_pkg::StDone:    if (res_ready_i) state_d = stw_pkg::StIdle;
      default:            state_d = stw_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    busy_o            = (state_q != stw_pkg::StIdle);
    res_valid_o       = (state_q == stw_pkg::StDone);
    res_o.out_symbol  = stw_pkg::FieldBits'(rsym_q);
    res_o.found       = rfound_q;
    res_o.next_state  = stw_pkg::FieldBits'(cur_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stw_pkg::StIdle;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    sym_q    <= sym_d;
    rsym_q   <= rsym_d;
    rfound_q <= rfound_d;
  end

endmodule

@@ src/sequential_transducer_walk.sv @@
// ----------------------------------------------------------------------------
// sequential_transducer_walk
// deterministic transducer over a sorted arc table, binary search per symbol
// ----------------------------------------------------------------------------
// beats: a load beat writes the table and gives no result
// an apply beat runs through the issue state, the compare state for its probes and the
// done state to its result register, with at most ceil(log2(n+1)) probes for n searched arcs
// flow: beats stall until a search hands on its result; one read port probe per cycle
// reset: arc count and current state go to 0, the arc table is not cleared
module sequential_transducer_walk #(
  parameter int unsigned TableDepth = stw_pkg::TableDepth,
  parameter int unsigned LabelBits  = stw_pkg::LabelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: arc count
  input  logic                          cfg_we_i,
  input  logic [stw_pkg::CountBits-1:0] cfg_wdata_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  stw_pkg::in_beat_t             in_data_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output stw_pkg::out_beat_t            out_data_o
);

  localparam int unsigned AddrBits = $clog2(TableDepth);
  localparam int unsigned CntBits  = $clog2(TableDepth + 1);

  logic [stw_pkg::CountBits-1:0] arc_count_q;

  logic                   in_accept, is_load, is_apply, idx_ok;
  logic                   busy, wr_en, rd_en;
  logic [AddrBits-1:0]    rd_addr;
  logic [4*LabelBits-1:0] wr_data, rd_data;
  logic [CntBits-1:0]     hi_init;

  logic                   res_valid, res_ready;
  stw_pkg::out_beat_t     res;
  stw_pkg::out_beat_t     out_q;
  logic                   out_valid_q, out_valid_d;

  // arc count register, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_count_q <= '0;
    end else if (cfg_we_i) begin
      arc_count_q <= cfg_wdata_i;
    end
  end

  // search window top, capped at the table depth
  assign hi_init = (32'(arc_count_q) > TableDepth) ? CntBits'(TableDepth)
                                                   : CntBits'(arc_count_q);

  // input beat decode
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;
  assign is_load    = (in_data_i.operation == stw_pkg::OpLoad);
  assign is_apply   = (in_data_i.operation == stw_pkg::OpApply);
  assign idx_ok     = (32'(in_data_i.arc_index) < TableDepth);

  // a load writes the table in the cycle it is taken; out of range index dropped
  assign wr_en   = in_accept && is_load && idx_ok;
  assign wr_data = {LabelBits'(in_data_i.arc_source),
                    LabelBits'(in_data_i.arc_input_label),
                    LabelBits'(in_data_i.arc_output_label),
                    LabelBits'(in_data_i.arc_target)};

  stw_arc_ram #(
    .Depth (TableDepth),
    .Width (4 * LabelBits)
  ) u_arc_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrBits'(in_data_i.arc_index)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer: one probe per cycle through the shared key compare
  stw_search #(
    .TableDepth (TableDepth),
    .LabelBits  (LabelBits)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept && is_apply),
    .first_i     (in_data_i.first_of_string),
    .symbol_i    (in_data_i.symbol),
    .hi_init_i   (hi_init),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register, lets the next item start while this beat waits
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // table is never written while a search runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> !busy)
    else $error("table write during search");

  // an accepted apply starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_apply) |=> busy)
    else $error("apply beat did not start a search");

  // a load leaves the block free for the next beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_load) |=> !busy)
    else $error("load beat left block busy");

  // a miss emits a zero label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.found || (out_data_o.out_symbol == '0)))
    else $error("miss with nonzero output label");

endmodule

@@ test/tb_sequential_transducer_walk.sv @@
// ----------------------------------------------------------------------------
// tb_sequential_transducer_walk
// self-checking bench for the sorted arc table transducer: loads arc tables,
// sets the arc count between phases and walks symbol strings through the
// block, checking every result beat against a cycle-free behavioral predictor
// ----------------------------------------------------------------------------
module tb_sequential_transducer_walk;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [stw_pkg::LabelBits-1:0] label_t;

  // drain pause, well above the worst case search at full depth
  localparam int unsigned SettleCycles = 20;
  // long receiver hold-off used to back the block up
  localparam int unsigned HoldCycles = 500;
  // sorted table shape: states times arcs per state fills the table
  localparam int unsigned NumStates = 64;
  localparam int unsigned ArcsPerState = 16;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [stw_pkg::CountBits-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  stw_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stw_pkg::out_beat_t out_data;

  // predictor copy of the block: arc table, walk state and arc count
  label_t arc_src [stw_pkg::TableDepth];
  label_t arc_in [stw_pkg::TableDepth];
  label_t arc_out [stw_pkg::TableDepth];
  label_t arc_dst [stw_pkg::TableDepth];
  label_t walk_state = '0;
  int unsigned arc_limit = 0;

  // results predicted but not yet seen on the output
  stw_pkg::out_beat_t predicted_steps[$];
  stw_pkg::out_beat_t want;

  // sorted table layout shared by the walk generator
  label_t state_ids [NumStates];
  label_t state_labels [NumStates][ArcsPerState];

  // idle rates in percent per cycle, and the hold-off request
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;

  // bookkeeping
  int unsigned fail_count = 0;
  int unsigned loads_seen = 0;
  int unsigned walks_seen = 0;
  int unsigned hits_seen = 0;

  sequential_transducer_walk u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // behavioral step: a load writes the table, an apply binary-searches it
  function automatic bit transduce(input stw_pkg::in_beat_t b,
                                   output stw_pkg::out_beat_t r);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit hit;
    r = '0;
    if (b.operation == stw_pkg::OpLoad) begin
      arc_src[b.arc_index] = b.arc_source;
      arc_in[b.arc_index]  = b.arc_input_label;
      arc_out[b.arc_index] = b.arc_output_label;
      arc_dst[b.arc_index] = b.arc_target;
      loads_seen++;
      return 1'b0;
    end
    if (b.first_of_string) walk_state = '0;
    // counts above the depth only search the physical table
    lo = 0;
    hi = (arc_limit > stw_pkg::TableDepth) ? stw_pkg::TableDepth : arc_limit;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = (lo + hi) / 2;
      if (arc_src[mid] == walk_state && arc_in[mid] == b.symbol) begin
        hit = 1'b1;
        r.out_symbol = arc_out[mid];
        walk_state = arc_dst[mid];
      end else if (arc_src[mid] < walk_state ||
                   (arc_src[mid] == walk_state && arc_in[mid] < b.symbol)) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    // a miss keeps the state, already cleared if the string restarted
    r.found = hit;
    r.next_state = walk_state;
    walks_seen++;
    if (hit) hits_seen++;
    return 1'b1;
  endfunction

  // offer one beat; called right after a rising edge, returns right after
  // the edge that took the beat, valid stays high for a following beat
  task automatic drive_beat(input stw_pkg::in_beat_t b);
    stw_pkg::out_beat_t r;
    bit taken;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    taken = 1'b0;
    while (!taken) begin
      // stall is settled mid-cycle, so the coming edge is known to take it
      @(negedge clk);
      if (!in_stall) begin
        taken = 1'b1;
        if (transduce(b, r)) predicted_steps = {predicted_steps, r};
      end
      @(posedge clk);
    end
  endtask

  // random filler for the fields a beat ignores
  function automatic stw_pkg::in_beat_t noise_beat();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(stw_pkg::in_beat_t)-1:0];
  endfunction

  task automatic load_arc(input int unsigned idx, input int unsigned src,
                          input int unsigned lin, input int unsigned lout,
                          input int unsigned dst);
    stw_pkg::in_beat_t b;
    b = noise_beat();
    b.operation        = stw_pkg::OpLoad;
    b.arc_index        = stw_pkg::IndexBits'(idx);
    b.arc_source       = stw_pkg::FieldBits'(src);
    b.arc_input_label  = stw_pkg::FieldBits'(lin);
    b.arc_output_label = stw_pkg::FieldBits'(lout);
    b.arc_target       = stw_pkg::FieldBits'(dst);
    drive_beat(b);
  endtask

  task automatic apply_symbol(input int unsigned sym, input bit first);
    stw_pkg::in_beat_t b;
    b = noise_beat();
    b.operation       = stw_pkg::OpApply;
    b.symbol          = stw_pkg::FieldBits'(sym);
    b.first_of_string = first;
    drive_beat(b);
  endtask

  // wait until every predicted result is out and the last load has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_arc_count(input int unsigned count);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= stw_pkg::CountBits'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    arc_limit = count & ((1 << stw_pkg::CountBits) - 1);
  endtask

  // walk the sorted table: mostly symbols that leave the current state,
  // some random symbols that miss, and an occasional string restart
  task automatic random_walk(input int unsigned n);
    stw_pkg::in_beat_t b;
    int j;
    label_t cur;
    repeat (n) begin
      b = noise_beat();
      b.operation = stw_pkg::OpApply;
      b.first_of_string = ($urandom_range(0, 99) < 8);
      cur = b.first_of_string ? '0 : walk_state;
      j = -1;
      for (int k = 0; k < NumStates; k++) begin
        if (state_ids[k] == cur) j = k;
      end
      if (j >= 0 && $urandom_range(0, 99) < 80) begin
        b.symbol = state_labels[j][$urandom_range(0, ArcsPerState - 1)];
      end else begin
        b.symbol = stw_pkg::FieldBits'($urandom_range(0, 4095));
      end
      drive_beat(b);
    end
  endtask

  // hand-picked table with extreme labels, empty count and string restarts
  task automatic test_directed_walks();
    send_idle = 30;
    recv_idle = 76;
    // empty table: nothing is probed, everything misses
    write_arc_count(0);
    apply_symbol(0, 1'b1);
    apply_symbol(4095, 1'b0);
    load_arc(0, 0, 0, 4095, 4095);
    load_arc(1, 0, 4095, 1, 5);
    load_arc(2, 5, 7, 2, 0);
    load_arc(3, 4095, 0, 0, 5);
    load_arc(4, 4095, 4095, 4095, 0);
    load_arc(1023, 4095, 4095, 4095, 4095);
    write_arc_count(5);
    apply_symbol(0, 1'b1);
    apply_symbol(4095, 1'b0);
    apply_symbol(4095, 1'b0);
    // a load in the middle of a string leaves the walk state alone
    load_arc(1023, 0, 0, 0, 0);
    apply_symbol(7, 1'b0);
    apply_symbol(3, 1'b0);
    apply_symbol(0, 1'b0);
    // hit that emits label zero
    apply_symbol(0, 1'b0);
    // restarts from state zero: a miss, then a hit
    apply_symbol(7, 1'b1);
    apply_symbol(4095, 1'b1);
  endtask

  // tiny unsorted tables with a small label space, so the search lands on
  // hits and misses alike; stray loads rewrite entries between walks
  task automatic test_unsorted_table();
    int unsigned count;
    for (int i = 0; i < 32; i++) begin
      load_arc(i, $urandom_range(0, 3), $urandom_range(0, 3),
               $urandom_range(0, 4095), $urandom_range(0, 3));
    end
    for (int round = 0; round < 6; round++) begin
      // smallest and largest counts of the written region at the ends
      if (round == 0) count = 1;
      else if (round == 5) count = 32;
      else count = $urandom_range(2, 32);
      write_arc_count(count);
      repeat (20) begin
        if ($urandom_range(0, 99) < 12) begin
          load_arc(($urandom_range(0, 1)) ? $urandom_range(0, 31) : $urandom_range(0, 1023),
                   $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 4095), $urandom_range(0, 3));
        end else begin
          apply_symbol(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 3),
                       $urandom_range(0, 99) < 15);
        end
      end
    end
  endtask

  // build a properly sorted table and grow the searched region in steps,
  // walking strings after each step; idling moves through its three modes
  task automatic test_growing_table();
    int unsigned bounds [8] = '{16, 48, 128, 256, 512, 768, 1000, 1024};
    int unsigned filled;
    for (int j = 0; j < NumStates; j++) begin
      state_ids[j] = stw_pkg::FieldBits'(j * 64 + $urandom_range(0, 63));
      for (int i = 0; i < ArcsPerState; i++) begin
        state_labels[j][i] = stw_pkg::FieldBits'(i * 256 + $urandom_range(0, 255));
      end
    end
    // the walk starts at state zero, and the top state is the widest label
    state_ids[0] = '0;
    state_ids[NumStates-1] = '1;
    filled = 0;
    for (int c = 0; c < 8; c++) begin
      if (c < 3) begin
        send_idle = 30;
        recv_idle = 76;
      end else if (c < 6) begin
        send_idle = 76;
        recv_idle = 30;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      while (filled < bounds[c]) begin
        load_arc(filled, state_ids[filled / ArcsPerState],
                 state_labels[filled / ArcsPerState][filled % ArcsPerState],
                 $urandom_range(0, 4095), state_ids[$urandom_range(0, NumStates - 1)]);
        filled++;
      end
      write_arc_count(bounds[c]);
      random_walk(40);
    end
  endtask

  // receiver holds off for a long stretch while walks keep coming
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    random_walk(40);
  endtask

  // count beyond the table depth still searches only the real entries
  task automatic test_count_above_depth();
    send_idle = 30;
    recv_idle = 30;
    write_arc_count((1 << stw_pkg::CountBits) - 1);
    random_walk(60);
  endtask

  task automatic check_field(input string name, input label_t exp_v, input label_t got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      if (fail_count <= 30) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      end
    end
  endtask

  // result side: take beats, compare against the oldest prediction,
  // then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_steps.size() == 0) begin
        fail_count++;
        if (fail_count <= 30) begin
          $display("%0t ns: unexpected result beat, expected none, got %h", $time, out_data);
        end
      end else begin
        want = predicted_steps.pop_front();
        check_field("out_symbol", want.out_symbol, out_data.out_symbol);
        check_field("found", label_t'(want.found), label_t'(out_data.found));
        check_field("next_state", want.next_state, out_data.next_state);
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walks();
    test_unsorted_table();
    test_growing_table();
    test_backpressure();
    test_count_above_depth();
    drain();
    $display("covered %0d arc loads and %0d symbol steps (%0d hits, %0d misses)",
             loads_seen, walks_seen, hits_seen, walks_seen - hits_seen);
    $display("arc counts from 0 up past the table depth, sorted and unsorted tables");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sequential_transducer_walk.f @@
src/stw_pkg.sv
src/stw_arc_ram.sv
src/stw_search.sv
src/sequential_transducer_walk.sv
test/tb_sequential_transducer_walk.sv
